### design/vn_pkg.sv
// Shared constants for the vector normalization block.
package vn_pkg;

   // Width of every multi-bit result field.
   localparam int unsigned OUT_W = 24;
   // Fraction bits of a unit component (Q1.22).
   localparam int unsigned UNIT_FRAC = 22;
   // Quotient bits produced by each divider lane.
   localparam int unsigned QUO_W = 24;
   // Largest value of a result field.
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
   // Threshold value after reset.
   localparam logic [OUT_W-1:0] THRESHOLD_RESET = 24'd1;
   // Number of component lanes.
   localparam int unsigned AXES = 3;
   // Opcode bit that selects a three-component vector.
   localparam logic OPCODE_3D = 1'b1;

endpackage

### design/vn_ifs.sv
// Channel interfaces of the vector normalization block.
interface vn_req_if #(parameter int unsigned COMPONENT_WIDTH = 24);
   logic                              valid;
   logic                              ready;
   logic                              opcode;
   logic signed [COMPONENT_WIDTH-1:0] x_in;
   logic signed [COMPONENT_WIDTH-1:0] y_in;
   logic signed [COMPONENT_WIDTH-1:0] z_in;
   modport source (output valid, opcode, x_in, y_in, z_in, input ready);
   modport sink (input valid, opcode, x_in, y_in, z_in, output ready);
endinterface

interface vn_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vn_pkg::OUT_W-1:0]      unit_x;
   logic signed [vn_pkg::OUT_W-1:0]      unit_y;
   logic signed [vn_pkg::OUT_W-1:0]      unit_z;
   logic        [vn_pkg::OUT_W-1:0]      magnitude;
   logic        [vn_pkg::OUT_W-1:0]      inv_magnitude;
   logic                                 degenerate;
   modport source (output valid, unit_x, unit_y, unit_z, magnitude, inv_magnitude,
                   degenerate, input ready);
   modport sink (input valid, unit_x, unit_y, unit_z, magnitude, inv_magnitude,
                 degenerate, output ready);
endinterface

interface vn_csr_if;
   logic                         valid;
   logic                         ready;
   logic [vn_pkg::OUT_W-1:0]     data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### design/vn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module vn_sqrt #(
   parameter int unsigned W = 24
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] sum_in,
   output logic [W-1:0]   root_out
);

   logic [W+1:0]   rem_ff  [W];
   logic [W-1:0]   root_ff [W];
   logic [2*W-1:0] sum_ff  [W];
   logic [W+1:0]   rem_in  [W];
   logic [W-1:0]   root_in [W];
   logic [2*W-1:0] sum_in_s[W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [W+1:0]   prev_rem;
      logic [W-1:0]   prev_root;
      logic [2*W-1:0] prev_sum;
      logic [W+3:0]   trial_num;
      logic [W+3:0]   trial_sub;
      logic [W+3:0]   trial_dif;

      // Stage input comes from the previous stage or the sum itself.
      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_sum  = sum_in;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_sum  = sum_ff[k-1];
      end

      // Bring down two bits and try to subtract 4*root+1.
      always_comb begin
         trial_num = {prev_rem, prev_sum[2*W-1:2*W-2]};
         trial_sub = {2'b00, prev_root, 2'b01};
         trial_dif = trial_num - trial_sub;
         sum_in_s[k] = {prev_sum[2*W-3:0], 2'b00};
         if (trial_num >= trial_sub) begin
            rem_in[k]  = trial_dif[W+1:0];
            root_in[k] = {prev_root[W-2:0], 1'b1};
         end else begin
            rem_in[k]  = trial_num[W+1:0];
            root_in[k] = {prev_root[W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            sum_ff[k]  <= sum_in_s[k];
         end
      end
   end

   assign root_out = root_ff[W-1];

endmodule

### design/vn_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per stage.
module vn_div_lane #(
   parameter int unsigned W  = 24,
   parameter int unsigned NW = 48
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [NW-1:0]            num,
   input  logic [W-1:0]             den,
   output logic [vn_pkg::QUO_W-1:0] quo,
   output logic                     ovf
);

   localparam int unsigned QW = vn_pkg::QUO_W;
   localparam int unsigned HW = NW - QW;

   logic [W-1:0]  rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [W-1:0]  den_ff [QW];
   logic          ovf_ff [QW];

   logic [HW-1:0] head;
   logic          ovf_first;

   // The quotient fits in QW bits only when the numerator head is below the divisor.
   assign head      = num[NW-1:QW];
   assign ovf_first = head >= HW'(den);

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [W-1:0]  prev_rem;
      logic [QW-1:0] prev_low;
      logic [QW-1:0] prev_quo;
      logic [W-1:0]  prev_den;
      logic          prev_ovf;
      logic [W:0]    trial;

      if (k == 0) begin : g_first
         assign prev_rem = head[W-1:0];
         assign prev_low = num[QW-1:0];
         assign prev_quo = '0;
         assign prev_den = den;
         assign prev_ovf = ovf_first;
      end else begin : g_next
         assign prev_rem = rem_ff[k-1];
         assign prev_low = low_ff[k-1];
         assign prev_quo = quo_ff[k-1];
         assign prev_den = den_ff[k-1];
         assign prev_ovf = ovf_ff[k-1];
      end

      assign trial = {prev_rem, prev_low[QW-1]};

      // Subtract the divisor when it fits and record the quotient bit.
      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= {1'b0, prev_den}) begin
               rem_ff[k] <= W'(trial - {1'b0, prev_den});
               quo_ff[k] <= {prev_quo[QW-2:0], 1'b1};
            end else begin
               rem_ff[k] <= trial[W-1:0];
               quo_ff[k] <= {prev_quo[QW-2:0], 1'b0};
            end
            low_ff[k] <= {prev_low[QW-2:0], 1'b0};
            den_ff[k] <= prev_den;
            ovf_ff[k] <= prev_ovf;
         end
      end
   end

   assign quo = quo_ff[QW-1];
   assign ovf = ovf_ff[QW-1];

endmodule

### design/vector_normalize.sv
// An accepted beat passes the input, square, sum, root, numerator, divider and output registers to its result beat.
// Throughput: one vector per cycle; a stalled result beat holds the whole pipeline.
// The square root takes one stage per root bit; each divider lane takes 24 stages.
// Reset clears the pipeline valid bits and sets the threshold to 1.
// The threshold port always accepts writes.
module vector_normalize #(
   parameter int unsigned COMPONENT_WIDTH = 24
) (
   input  logic         clock,
   input  logic         reset,
   vn_req_if.sink       req_bus,
   vn_rsp_if.source     rsp_bus,
   vn_csr_if.sink       csr_bus
);

   localparam int unsigned W    = COMPONENT_WIDTH;
   localparam int unsigned OW   = vn_pkg::OUT_W;
   localparam int unsigned QW   = vn_pkg::QUO_W;
   localparam int unsigned NW   = (W + QW > 34) ? W + QW : 34;
   localparam int unsigned AX   = vn_pkg::AXES;
   localparam int unsigned LAT  = W + QW + 5;
   localparam int unsigned SQ_D = W + 3;

   typedef struct packed {
      logic [AX-1:0] neg;
   } sign_type;

   typedef struct packed {
      logic [AX-1:0] neg;
      logic [W-1:0]  mag;
      logic          degen;
   } side_type;

   logic                en;
   logic [LAT-1:0]      vld_ff;
   logic [OW-1:0]       threshold_ff;

   logic [W-1:0]        abs_ff [AX];
   sign_type            sign_ff [SQ_D];
   logic [2*W-1:0]      sqr_ff [AX];
   logic [2*W-1:0]      sum_ff;
   logic [W-1:0]        root;
   logic [W-1:0]        abs_dly_ff [AX][W+2];

   logic [NW-1:0]       num_ff [AX+1];
   logic [W-1:0]        den_ff;
   side_type            side_ff [QW+1];

   logic [QW-1:0]       quo [AX+1];
   logic                ovf [AX+1];

   logic signed [W-1:0] comp [AX];
   logic [W-1:0]        abs_in [AX];
   logic [AX-1:0]       neg_in;
   logic                mag_zero;
   side_type            side_last;

   logic signed [OW-1:0] unit_x_ff, unit_y_ff, unit_z_ff;
   logic signed [OW-1:0] unit_in [AX];
   logic [OW-1:0]       magnitude_ff, inv_ff;
   logic                degen_out_ff;

   // The whole pipeline moves unless a result beat sits unclaimed.
   assign en            = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         threshold_ff <= vn_pkg::THRESHOLD_RESET;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
         end
         if (csr_bus.valid) begin
            threshold_ff <= csr_bus.data;
         end
      end
   end

   // Split each component into magnitude and sign; z drops out in 2-D mode.
   assign comp[0] = req_bus.x_in;
   assign comp[1] = req_bus.y_in;
   assign comp[2] = (req_bus.opcode == vn_pkg::OPCODE_3D) ? req_bus.z_in : '0;

   for (genvar a = 0; a < AX; a++) begin : g_axis
      assign neg_in[a] = comp[a][W-1];
      assign abs_in[a] = neg_in[a] ? W'(-comp[a]) : W'(comp[a]);

      always_ff @(posedge clock) begin
         if (en) begin
            abs_ff[a] <= abs_in[a];
            sqr_ff[a] <= abs_ff[a] * abs_ff[a];
         end
      end
   end

   // Signs ride alongside the squares, the sum and the root stages.
   always_ff @(posedge clock) begin
      if (en) begin
         sign_ff[0].neg <= neg_in;
         for (int i = 1; i < SQ_D; i++) begin
            sign_ff[i] <= sign_ff[i-1];
         end
         sum_ff <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
      end
   end

   vn_sqrt #(.W(W)) u_sqrt (
      .clock    (clock),
      .en       (en),
      .sum_in   (sum_ff),
      .root_out (root)
   );

   // Component magnitudes wait beside the root stages.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < AX; a++) begin
            abs_dly_ff[a][0] <= abs_ff[a];
            for (int i = 1; i < W + 2; i++) begin
               abs_dly_ff[a][i] <= abs_dly_ff[a][i-1];
            end
         end
      end
   end

   // Build the rounded numerators and test the threshold.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < AX; a++) begin
            num_ff[a] <= (NW'(abs_dly_ff[a][W+1]) << vn_pkg::UNIT_FRAC) + NW'(root >> 1);
         end
         num_ff[AX]        <= (NW'(1) << 32) + NW'(root >> 1);
         den_ff            <= root;
         side_ff[0].neg    <= sign_ff[SQ_D-1].neg;
         side_ff[0].mag    <= root;
         side_ff[0].degen  <= (OW + W)'(root) < (OW + W)'(threshold_ff);
         for (int i = 1; i <= QW; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Four divider lanes: three unit components and the reciprocal.
   for (genvar l = 0; l <= AX; l++) begin : g_lane
      vn_div_lane #(.W(W), .NW(NW)) u_lane (
         .clock (clock),
         .en    (en),
         .num   (num_ff[l]),
         .den   (den_ff),
         .quo   (quo[l]),
         .ovf   (ovf[l])
      );
   end

   // Merge the lanes into one result beat.
   assign side_last = side_ff[QW];
   assign mag_zero  = side_last.mag == '0;

   for (genvar a = 0; a < AX; a++) begin : g_merge
      assign unit_in[a] = (side_last.degen || mag_zero) ? '0 :
                          side_last.neg[a] ? OW'(-quo[a]) : OW'(quo[a]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_x_ff    <= unit_in[0];
         unit_y_ff    <= unit_in[1];
         unit_z_ff    <= unit_in[2];
         degen_out_ff <= side_last.degen;
         if ((OW + W)'(side_last.mag) > (OW + W)'(vn_pkg::OUT_MAX)) begin
            magnitude_ff <= vn_pkg::OUT_MAX;
         end else begin
            magnitude_ff <= OW'(side_last.mag);
         end
         if (side_last.degen) begin
            inv_ff <= '0;
         end else if (ovf[AX]) begin
            inv_ff <= vn_pkg::OUT_MAX;
         end else begin
            inv_ff <= quo[AX];
         end
      end
   end

   assign rsp_bus.valid         = vld_ff[LAT-1];
   assign rsp_bus.unit_x        = unit_x_ff;
   assign rsp_bus.unit_y        = unit_y_ff;
   assign rsp_bus.unit_z        = unit_z_ff;
   assign rsp_bus.magnitude     = magnitude_ff;
   assign rsp_bus.inv_magnitude = inv_ff;
   assign rsp_bus.degenerate    = degen_out_ff;

   // A degenerate result carries no reciprocal and no direction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.degenerate |->
         rsp_bus.inv_magnitude == '0 && rsp_bus.unit_x == '0 &&
         rsp_bus.unit_y == '0 && rsp_bus.unit_z == '0)
      else $error("degenerate result with nonzero direction");

   // The input side stalls exactly when a result beat is held back.
   assert property (@(posedge clock) disable iff (reset)
      req_bus.ready == (!rsp_bus.valid || rsp_bus.ready))
      else $error("input ready does not follow output stall");

   // A zero magnitude that is not degenerate has a saturated reciprocal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.degenerate && rsp_bus.magnitude == '0 |->
         rsp_bus.inv_magnitude == vn_pkg::OUT_MAX)
      else $error("zero magnitude reciprocal not saturated");

   // Reset restores the threshold.
   assert property (@(posedge clock) reset |=> threshold_ff == vn_pkg::THRESHOLD_RESET)
      else $error("threshold not restored by reset");

endmodule
